// ===== hw/rtl/tmp_pkg.sv =====
// Shared types, constants and helper functions for the trapezoid motion profile core.
// No dependencies; all files but the two interfaces use this package by scoped names.
`default_nettype none

package tmp_pkg;

  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_START_POS  = 3'd0;
  localparam logic [2:0] REG_END_POS    = 3'd1;
  localparam logic [2:0] REG_VEL_LIMIT  = 3'd2;
  localparam logic [2:0] REG_ACC_LIMIT  = 3'd3;
  localparam logic [2:0] REG_TARGET_DUR = 3'd4;

  localparam logic [30:0] TMAX    = 31'h7FFF_FFFF;
  localparam logic [33:0] MAG_CAP = 34'h2_0000_0000;

  typedef struct packed {
    logic signed [31:0] sample_time;
    logic               nonpos;
  } item_t;

  typedef struct packed {
    logic [31:0] start_position;
    logic [31:0] end_position;
    logic [30:0] velocity_limit;
    logic [30:0] accel_limit;
    logic [30:0] target_duration;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [33:0] a;
    logic [32:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] n;
    logic [31:0] d;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] q;
    logic [31:0] r;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] x;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

  // Clamp a magnitude to 2^33.
  function automatic logic [33:0] cap_mag(input logic [63:0] v);
    logic [33:0] res;
    if (v > {30'b0, MAG_CAP}) begin
      res = MAG_CAP;
    end else begin
      res = v[33:0];
    end
    return res;
  endfunction

  // Saturate to signed 32 bits; top bit of the result flags a clip.
  function automatic logic [32:0] sat32(input logic signed [35:0] v);
    logic [32:0] res;
    if (v > 36'sh0_7FFF_FFFF) begin
      res = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -36'sh0_8000_0000) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tmp_sample_if.sv =====
// Sample channel: valid/ready handshake carrying one sample time.
// No dependencies.
`default_nettype none

interface tmp_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_time;

  modport source (output valid, output sample_time, input ready);
  modport sink (input valid, input sample_time, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tmp_result_if.sv =====
// Result channel: valid/ready handshake carrying one profile result item.
// No dependencies.
`default_nettype none

interface tmp_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [31:0] velocity;
  logic signed [31:0] sens_start;
  logic signed [31:0] sens_end;
  logic [30:0]        move_duration;
  logic               saturated;

  modport source (output valid, output position, output velocity, output sens_start,
                  output sens_end, output move_duration, output saturated, input ready);
  modport sink (input valid, input position, input velocity, input sens_start,
                input sens_end, input move_duration, input saturated, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tmp_front.sv =====
// Front end: accepts sample items, tags non-positive times, and queues them for the back end.
// Depends on tmp_pkg and tmp_sample_if.
`default_nettype none

module tmp_front (
  input  wire logic           clk,
  input  wire logic           rst,
  tmp_sample_if.sink          sample,
  output tmp_pkg::item_t      item,
  output logic                item_valid,
  input  wire logic           item_pop
);

  tmp_pkg::item_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;

  assign sample.ready = (count != 2'd2);
  assign push         = sample.valid && sample.ready;
  assign item_valid   = (count != 2'd0);
  assign item         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{sample_time: sample.sample_time,
                         nonpos: (sample.sample_time[31] || (sample.sample_time == 32'sd0))};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (item_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, item_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tmp_mul.sv =====
// Shared multiplier: 34 x 33 bit product, eight multiplier bits per cycle.
// Depends on tmp_pkg.
`default_nettype none

module tmp_mul (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tmp_pkg::mul_req_t req,
  output tmp_pkg::mul_rsp_t     rsp
);

  localparam int DIGITS = 5;

  logic [63:0] acc;
  logic [63:0] mcand;
  logic [39:0] mplier;
  logic [2:0]  cnt;
  logic        busy;
  logic        done;

  assign rsp.done = done;
  assign rsp.p    = acc;

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc    <= '0;
      mcand  <= {30'b0, req.a};
      mplier <= {7'b0, req.b};
    end else if (busy) begin
      acc    <= acc + (mcand * {56'b0, mplier[7:0]});
      mcand  <= {mcand[55:0], 8'b0};
      mplier <= {8'b0, mplier[39:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'(DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tmp_div.sv =====
// Shared divider: 64 by 32 bit restoring division, one quotient bit per cycle.
// Depends on tmp_pkg.
`default_nettype none

module tmp_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tmp_pkg::div_req_t req,
  output tmp_pkg::div_rsp_t     rsp
);

  logic [63:0] nq;
  logic [31:0] den;
  logic [31:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic        ge;

  assign rem_sh = {rem, nq[63]};
  assign diff   = rem_sh - {1'b0, den};
  assign ge     = (rem_sh >= {1'b0, den});

  assign rsp.done = done;
  assign rsp.q    = nq;
  assign rsp.r    = rem;

  always_ff @(posedge clk) begin
    if (req.start) begin
      nq  <= req.n;
      den <= req.d;
      rem <= '0;
    end else if (busy) begin
      nq  <= {nq[62:0], ge};
      rem <= ge ? diff[31:0] : rem_sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tmp_sqrt.sv =====
// Integer square root of a 64-bit value, one result bit per cycle.
// Depends on tmp_pkg.
`default_nettype none

module tmp_sqrt (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tmp_pkg::sqrt_req_t req,
  output tmp_pkg::sqrt_rsp_t     rsp
);

  logic [63:0] x;
  logic [63:0] root;
  logic [63:0] bitv;
  logic [63:0] trial;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;

  assign trial    = root + bitv;
  assign rsp.done = done;
  assign rsp.root = root[31:0];

  always_ff @(posedge clk) begin
    if (req.start) begin
      x    <= req.x;
      root <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (x >= trial) begin
        x    <= x - trial;
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tmp_back.sv =====
// Back end: plans the move on demand and evaluates each queued sample into the result register.
// Depends on tmp_pkg and tmp_result_if; drives the shared multiply, divide and square root units.
`default_nettype none

module tmp_back #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tmp_pkg::cfg_t      cfg,
  input  wire logic               cfg_wr,
  input  wire logic               item_valid,
  input  wire tmp_pkg::item_t     item,
  output logic                    item_pop,
  output tmp_pkg::mul_req_t       mul_req,
  input  wire tmp_pkg::mul_rsp_t  mul_rsp,
  output tmp_pkg::div_req_t       div_req,
  input  wire tmp_pkg::div_rsp_t  div_rsp,
  output tmp_pkg::sqrt_req_t      sqrt_req,
  input  wire tmp_pkg::sqrt_rsp_t sqrt_rsp,
  tmp_result_if.source            result
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_PLAN  = 5'd1;
  localparam logic [4:0] S_PMA   = 5'd2;
  localparam logic [4:0] S_PVV   = 5'd3;
  localparam logic [4:0] S_CT1   = 5'd4;
  localparam logic [4:0] S_CT2   = 5'd5;
  localparam logic [4:0] S_TQ    = 5'd6;
  localparam logic [4:0] S_TR    = 5'd7;
  localparam logic [4:0] S_TS    = 5'd8;
  localparam logic [4:0] S_TM    = 5'd9;
  localparam logic [4:0] S_TD    = 5'd10;
  localparam logic [4:0] S_STR   = 5'd11;
  localparam logic [4:0] S_MDM   = 5'd12;
  localparam logic [4:0] S_MDD   = 5'd13;
  localparam logic [4:0] S_X1    = 5'd14;
  localparam logic [4:0] S_X2    = 5'd15;
  localparam logic [4:0] S_X3    = 5'd16;
  localparam logic [4:0] S_X4    = 5'd17;
  localparam logic [4:0] S_X5    = 5'd18;
  localparam logic [4:0] S_FIN   = 5'd19;
  localparam logic [4:0] S_CLASS = 5'd20;
  localparam logic [4:0] S_A1    = 5'd21;
  localparam logic [4:0] S_A2    = 5'd22;
  localparam logic [4:0] S_C1    = 5'd23;
  localparam logic [4:0] S_C2    = 5'd24;
  localparam logic [4:0] S_C3    = 5'd25;
  localparam logic [4:0] S_D1    = 5'd26;
  localparam logic [4:0] S_D2    = 5'd27;
  localparam logic [4:0] S_D3    = 5'd28;
  localparam logic [4:0] S_RES   = 5'd29;

  localparam logic [33:0] ONE     = 34'(1) << FRAC_BITS;
  localparam logic [63:0] TRI_LIM = 64'(1) << (60 - FRAC_BITS);

  logic [4:0]  state;
  logic        plan_ready;
  logic        dir_neg;
  logic        clipped;
  logic [30:0] t1;
  logic [30:0] t2;
  logic [30:0] dur;
  logic [30:0] vs;
  logic [30:0] as;
  logic [31:0] dsl;
  logic [32:0] mag;
  logic [63:0] acc;
  logic [31:0] md_d;
  logic [4:0]  md_ret;
  logic [30:0] tp;
  logic        smp_np;
  logic [30:0] rr;
  logic [33:0] dmag;
  logic [33:0] vmag;
  logic [33:0] sens;
  logic        seg_end;

  logic               res_valid;
  logic signed [31:0] res_pos;
  logic signed [31:0] res_vel;
  logic signed [31:0] res_ss;
  logic signed [31:0] res_se;
  logic [30:0]        res_dur;
  logic               res_sat;

  logic signed [32:0] dpos;
  logic [32:0]        mag_in;
  logic [30:0]        v_in;
  logic [30:0]        a_in;
  logic [64:0]        csum;
  logic [30:0]        dur_c;
  logic [30:0]        t2_c;
  logic [30:0]        t1_c;
  logic [63:0]        d_raw;
  logic [63:0]        cr_sum;
  logic               out_free;
  logic signed [31:0] base;
  logic signed [35:0] pos36;
  logic signed [35:0] vel36;
  logic signed [35:0] ss36;
  logic signed [35:0] se36;
  logic [32:0]        pos_s;
  logic [32:0]        vel_s;
  logic [32:0]        ss_s;
  logic [32:0]        se_s;

  assign item_pop = (state == S_IDLE) && item_valid;
  assign out_free = !res_valid || result.ready;

  always_comb begin
    dpos   = {cfg.end_position[31], cfg.end_position}
           - {cfg.start_position[31], cfg.start_position};
    mag_in = dpos[32] ? 33'(-dpos) : 33'(dpos);
    if (mag_in == 33'd0) begin
      mag_in = 33'd1;
    end
    v_in   = (cfg.velocity_limit == 31'd0) ? 31'd1 : cfg.velocity_limit;
    a_in   = (cfg.accel_limit == 31'd0) ? 31'd1 : cfg.accel_limit;

    // Cruise plan: clip the total, then keep the segment times ordered.
    csum   = {1'b0, acc} + {1'b0, div_rsp.q};
    dur_c  = (csum > {34'b0, tmp_pkg::TMAX}) ? tmp_pkg::TMAX : csum[30:0];
    t2_c   = (div_rsp.q > {33'b0, dur_c}) ? dur_c : div_rsp.q[30:0];
    t1_c   = (acc > {33'b0, t2_c}) ? t2_c : acc[30:0];

    d_raw  = mul_rsp.p >> FRAC_BITS;
    cr_sum = acc + {30'b0, tmp_pkg::cap_mag(mul_rsp.p >> FRAC_BITS)};

    // Accel and cruise run away from start; decel runs back from end.
    base   = seg_end ? $signed(cfg.end_position) : $signed(cfg.start_position);
    pos36  = (dir_neg ^ seg_end) ? (36'(base) - $signed({2'b0, dmag}))
                                 : (36'(base) + $signed({2'b0, dmag}));
    vel36  = dir_neg ? -$signed({2'b0, vmag}) : $signed({2'b0, vmag});
    ss36   = $signed({2'b0, sens});
    se36   = $signed({2'b0, ONE}) - $signed({2'b0, sens});
    pos_s  = tmp_pkg::sat32(pos36);
    vel_s  = tmp_pkg::sat32(vel36);
    ss_s   = tmp_pkg::sat32(ss36);
    se_s   = tmp_pkg::sat32(se36);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      plan_ready    <= 1'b0;
      res_valid     <= 1'b0;
      mul_req.start <= 1'b0;
      div_req.start <= 1'b0;
      sqrt_req.start <= 1'b0;
    end else begin
      mul_req.start  <= 1'b0;
      div_req.start  <= 1'b0;
      sqrt_req.start <= 1'b0;
      if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      if (cfg_wr) begin
        plan_ready <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            tp     <= item.sample_time[30:0];
            smp_np <= item.nonpos;
            state  <= plan_ready ? S_CLASS : S_PLAN;
          end
        end
        S_PLAN: begin
          dir_neg <= dpos[32];
          mag     <= mag_in;
          vs      <= v_in;
          as      <= a_in;
          clipped <= 1'b0;
          mul_req <= '{start: 1'b1, a: 34'(mag_in), b: 33'(a_in)};
          state   <= S_PMA;
        end
        S_PMA: begin
          if (mul_rsp.done) begin
            acc     <= mul_rsp.p;
            mul_req <= '{start: 1'b1, a: 34'(vs), b: 33'(vs)};
            state   <= S_PVV;
          end
        end
        S_PVV: begin
          if (mul_rsp.done) begin
            if (acc > mul_rsp.p) begin
              div_req <= '{start: 1'b1, n: 64'(vs) << FRAC_BITS, d: 32'(as)};
              state   <= S_CT1;
            end else begin
              div_req <= '{start: 1'b1, n: 64'(mag) << FRAC_BITS, d: 32'(as)};
              state   <= S_TQ;
            end
          end
        end
        S_CT1: begin
          if (div_rsp.done) begin
            acc     <= div_rsp.q;
            div_req <= '{start: 1'b1, n: 64'(mag) << FRAC_BITS, d: 32'(vs)};
            state   <= S_CT2;
          end
        end
        S_CT2: begin
          if (div_rsp.done) begin
            dur <= dur_c;
            t2  <= t2_c;
            t1  <= t1_c;
            dsl <= 32'(vs);
            if (csum > {34'b0, tmp_pkg::TMAX}) begin
              clipped <= 1'b1;
            end
            state <= S_STR;
          end
        end
        S_TQ: begin
          if (div_rsp.done) begin
            if (div_rsp.q >= TRI_LIM) begin
              t1      <= 31'h3FFF_FFFF;
              clipped <= 1'b1;
              state   <= S_TM;
            end else begin
              acc     <= div_rsp.q;
              div_req <= '{start: 1'b1, n: 64'(div_rsp.r) << FRAC_BITS, d: 32'(as)};
              state   <= S_TR;
            end
          end
        end
        S_TR: begin
          if (div_rsp.done) begin
            sqrt_req <= '{start: 1'b1, x: (acc << FRAC_BITS) + div_rsp.q};
            state    <= S_TS;
          end
        end
        S_TS: begin
          if (sqrt_rsp.done) begin
            t1    <= sqrt_rsp.root[30:0];
            state <= S_TM;
          end
        end
        S_TM: begin
          mul_req <= '{start: 1'b1, a: 34'(as), b: 33'(t1)};
          state   <= S_TD;
        end
        S_TD: begin
          if (mul_rsp.done) begin
            if (d_raw == 64'd0) begin
              dsl <= 32'd1;
            end else if (d_raw > 64'h0000_0000_FFFF_FFFF) begin
              dsl     <= 32'hFFFF_FFFF;
              clipped <= 1'b1;
            end else begin
              dsl <= d_raw[31:0];
            end
            t2    <= t1;
            dur   <= {t1[29:0], 1'b0};
            state <= S_STR;
          end
        end
        S_STR: begin
          if ((cfg.target_duration != 31'd0) && (dur != 31'd0)) begin
            mul_req <= '{start: 1'b1, a: 34'(t1), b: 33'(cfg.target_duration)};
            md_d    <= 32'(dur);
            md_ret  <= S_X1;
            state   <= S_MDM;
          end else begin
            state <= S_FIN;
          end
        end
        S_MDM: begin
          if (mul_rsp.done) begin
            div_req <= '{start: 1'b1, n: mul_rsp.p, d: md_d};
            state   <= S_MDD;
          end
        end
        S_MDD: begin
          if (div_rsp.done) begin
            state <= md_ret;
          end
        end
        S_X1: begin
          t1      <= div_rsp.q[30:0];
          mul_req <= '{start: 1'b1, a: 34'(t2), b: 33'(cfg.target_duration)};
          md_d    <= 32'(dur);
          md_ret  <= S_X2;
          state   <= S_MDM;
        end
        S_X2: begin
          t2      <= div_rsp.q[30:0];
          mul_req <= '{start: 1'b1, a: 34'(vs), b: 33'(dur)};
          md_d    <= 32'(cfg.target_duration);
          md_ret  <= S_X3;
          state   <= S_MDM;
        end
        S_X3: begin
          if (div_rsp.q > {33'b0, tmp_pkg::TMAX}) begin
            vs      <= tmp_pkg::TMAX;
            clipped <= 1'b1;
          end else begin
            vs <= div_rsp.q[30:0];
          end
          mul_req <= '{start: 1'b1, a: 34'(as), b: 33'(dur)};
          md_d    <= 32'(cfg.target_duration);
          md_ret  <= S_X4;
          state   <= S_MDM;
        end
        S_X4: begin
          if (div_rsp.q > {33'b0, tmp_pkg::TMAX}) begin
            as      <= tmp_pkg::TMAX;
            clipped <= 1'b1;
            dur     <= cfg.target_duration;
            state   <= S_FIN;
          end else begin
            mul_req <= '{start: 1'b1, a: 34'(div_rsp.q[30:0]), b: 33'(dur)};
            md_d    <= 32'(cfg.target_duration);
            md_ret  <= S_X5;
            state   <= S_MDM;
          end
        end
        S_X5: begin
          if (div_rsp.q > {33'b0, tmp_pkg::TMAX}) begin
            as      <= tmp_pkg::TMAX;
            clipped <= 1'b1;
          end else begin
            as <= div_rsp.q[30:0];
          end
          dur   <= cfg.target_duration;
          state <= S_FIN;
        end
        S_FIN: begin
          plan_ready <= 1'b1;
          state      <= S_CLASS;
        end
        S_CLASS: begin
          if (smp_np) begin
            dmag    <= '0;
            vmag    <= '0;
            sens    <= ONE;
            seg_end <= 1'b0;
            state   <= S_RES;
          end else if (tp < t1) begin
            mul_req <= '{start: 1'b1, a: 34'(as), b: 33'(tp)};
            state   <= S_A1;
          end else if (tp < t2) begin
            mul_req <= '{start: 1'b1, a: 34'(as), b: 33'(t1)};
            state   <= S_C1;
          end else if (tp < dur) begin
            rr      <= dur - tp;
            mul_req <= '{start: 1'b1, a: 34'(as), b: 33'(dur - tp)};
            state   <= S_D1;
          end else begin
            dmag    <= '0;
            vmag    <= '0;
            sens    <= '0;
            seg_end <= 1'b1;
            state   <= S_RES;
          end
        end
        S_A1: begin
          if (mul_rsp.done) begin
            vmag    <= tmp_pkg::cap_mag(mul_rsp.p >> FRAC_BITS);
            mul_req <= '{start: 1'b1, a: tmp_pkg::cap_mag(mul_rsp.p >> FRAC_BITS),
                         b: 33'(tp)};
            state   <= S_A2;
          end
        end
        S_A2: begin
          if (mul_rsp.done) begin
            dmag    <= tmp_pkg::cap_mag(mul_rsp.p >> (FRAC_BITS + 1));
            sens    <= ONE;
            seg_end <= 1'b0;
            state   <= S_RES;
          end
        end
        S_C1: begin
          if (mul_rsp.done) begin
            mul_req <= '{start: 1'b1, a: tmp_pkg::cap_mag(mul_rsp.p >> FRAC_BITS),
                         b: 33'(t1)};
            state   <= S_C2;
          end
        end
        S_C2: begin
          if (mul_rsp.done) begin
            acc     <= {30'b0, tmp_pkg::cap_mag(mul_rsp.p >> (FRAC_BITS + 1))};
            mul_req <= '{start: 1'b1, a: 34'(vs), b: 33'(tp - t1)};
            state   <= S_C3;
          end
        end
        S_C3: begin
          if (mul_rsp.done) begin
            dmag    <= tmp_pkg::cap_mag(cr_sum);
            vmag    <= 34'(vs);
            sens    <= ONE;
            seg_end <= 1'b0;
            state   <= S_RES;
          end
        end
        S_D1: begin
          if (mul_rsp.done) begin
            vmag    <= tmp_pkg::cap_mag(mul_rsp.p >> FRAC_BITS);
            div_req <= '{start: 1'b1, n: mul_rsp.p, d: dsl};
            state   <= S_D2;
          end
        end
        S_D2: begin
          if (div_rsp.done) begin
            sens    <= tmp_pkg::cap_mag(div_rsp.q);
            mul_req <= '{start: 1'b1, a: vmag, b: 33'(rr)};
            state   <= S_D3;
          end
        end
        S_D3: begin
          if (mul_rsp.done) begin
            dmag    <= tmp_pkg::cap_mag(mul_rsp.p >> (FRAC_BITS + 1));
            seg_end <= 1'b1;
            state   <= S_RES;
          end
        end
        S_RES: begin
          if (out_free) begin
            res_valid <= 1'b1;
            res_pos   <= pos_s[31:0];
            res_vel   <= vel_s[31:0];
            res_ss    <= ss_s[31:0];
            res_se    <= se_s[31:0];
            res_dur   <= dur;
            res_sat   <= clipped | pos_s[32] | vel_s[32] | ss_s[32] | se_s[32];
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid         = res_valid;
  assign result.position      = res_pos;
  assign result.velocity      = res_vel;
  assign result.sens_start    = res_ss;
  assign result.sens_end      = res_se;
  assign result.move_duration = res_dur;
  assign result.saturated     = res_sat;

endmodule

`default_nettype wire

// ===== hw/rtl/trapezoid_motion_profile_core.sv =====
// Top level of the trapezoid motion profile core: APB register file, front queue, back end.
// Depends on tmp_pkg, tmp_sample_if, tmp_result_if, tmp_front, tmp_mul, tmp_div, tmp_sqrt,
// tmp_back.
`default_nettype none

// The core plans a trapezoidal (or, for short moves, triangular) move from start_position to
// end_position under velocity_limit and accel_limit, optionally stretched to target_duration,
// and turns each sample time into position, velocity, the position's sensitivity to start and
// end, and the planned duration, all Q16.16 with saturation flagged in saturated. Registers sit
// on the APB port at byte offsets 0x00 start, 0x04 end, 0x08 speed limit, 0x0C acceleration
// limit and 0x10 target duration; write them only while no sample is in flight. Any register
// write drops the plan, and the next sample re-plans first. Samples enter a two-item queue and
// are evaluated one at a time by a sequencer around a shared multiplier (8 multiplier bits per
// cycle), a 64/32 divider (one bit per cycle) and a square root unit. A sample at or before
// zero, or at or past the end, needs no arithmetic; one on the acceleration ramp takes two
// products, one in cruise three, and one on the deceleration ramp two products and a divide.
// Results wait in an output register, so the queue keeps taking samples while the downstream
// side stalls, until the queue is full.

module trapezoid_motion_profile_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  tmp_sample_if.sink                      sample,
  tmp_result_if.source                    result,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tmp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  tmp_pkg::cfg_t      cfg;
  logic               wr_en;
  logic               cfg_wr;
  logic [2:0]         reg_idx;
  tmp_pkg::item_t     item;
  logic               item_valid;
  logic               item_pop;
  tmp_pkg::mul_req_t  mul_req;
  tmp_pkg::mul_rsp_t  mul_rsp;
  tmp_pkg::div_req_t  div_req;
  tmp_pkg::div_rsp_t  div_rsp;
  tmp_pkg::sqrt_req_t sqrt_req;
  tmp_pkg::sqrt_rsp_t sqrt_rsp;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // Register writes; an address past the last register is dropped and keeps the plan.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_position  <= '0;
      cfg.end_position    <= '0;
      cfg.velocity_limit  <= 31'd65536;
      cfg.accel_limit     <= 31'd65536;
      cfg.target_duration <= '0;
      cfg_wr              <= 1'b0;
    end else begin
      cfg_wr <= 1'b0;
      if (wr_en) begin
        unique case (reg_idx)
          tmp_pkg::REG_START_POS: begin
            cfg.start_position <= pwdata;
            cfg_wr             <= 1'b1;
          end
          tmp_pkg::REG_END_POS: begin
            cfg.end_position <= pwdata;
            cfg_wr           <= 1'b1;
          end
          tmp_pkg::REG_VEL_LIMIT: begin
            cfg.velocity_limit <= pwdata[30:0];
            cfg_wr             <= 1'b1;
          end
          tmp_pkg::REG_ACC_LIMIT: begin
            cfg.accel_limit <= pwdata[30:0];
            cfg_wr          <= 1'b1;
          end
          tmp_pkg::REG_TARGET_DUR: begin
            cfg.target_duration <= pwdata[30:0];
            cfg_wr              <= 1'b1;
          end
          default: cfg_wr <= 1'b0;
        endcase
      end
    end
  end

  // Read back the register image; unmapped offsets read as zero.
  always_comb begin
    unique case (reg_idx)
      tmp_pkg::REG_START_POS:  prdata = cfg.start_position;
      tmp_pkg::REG_END_POS:    prdata = cfg.end_position;
      tmp_pkg::REG_VEL_LIMIT:  prdata = {1'b0, cfg.velocity_limit};
      tmp_pkg::REG_ACC_LIMIT:  prdata = {1'b0, cfg.accel_limit};
      tmp_pkg::REG_TARGET_DUR: prdata = {1'b0, cfg.target_duration};
      default:                 prdata = '0;
    endcase
  end

  tmp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  tmp_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  tmp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  tmp_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  tmp_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cfg_wr     (cfg_wr),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .mul_req    (mul_req),
    .mul_rsp    (mul_rsp),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .sqrt_req   (sqrt_req),
    .sqrt_rsp   (sqrt_rsp),
    .result     (result)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for trapezoid_motion_profile_core: APB plan setup, sample stream,
// result stream, and a cycle-free predictor of the planned trapezoidal/triangular profile.
// Depends on tmp_pkg, tmp_sample_if, tmp_result_if and the core RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int F = 16;
  localparam longint unsigned ONE_Q = 64'd1 << F;
  localparam longint unsigned CAP = 64'd1 << 33;
  localparam longint unsigned T_MAX = 64'h7FFF_FFFF;

  typedef struct {
    logic [31:0] position;
    logic [31:0] velocity;
    logic [31:0] sens_start;
    logic [31:0] sens_end;
    logic [30:0] move_duration;
    logic        saturated;
  } profile_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [tmp_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  tmp_sample_if sample ();
  tmp_result_if result ();

  trapezoid_motion_profile_core dut (
    .clk(clk), .rst(rst), .sample(sample), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register mirror and plan state of the predictor.
  logic [31:0] m_start, m_end;
  logic [30:0] m_vlim, m_alim, m_tdur;
  bit plan_valid, dir_neg, plan_clip;
  longint unsigned p_t1, p_t2, p_total, p_vel, p_acc, p_slope;

  profile_t expected_q[$];
  int mismatches = 0;
  int burst_left = 0;
  int hold_left = 0;

  function automatic longint unsigned mul_capped(longint unsigned a, longint unsigned b, int sh);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    if (p[127:64] != 0) return CAP;
    p = p >> sh;
    return (p[63:0] > CAP) ? CAP : p[63:0];
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  function automatic logic [32:0] clamp32(longint v);
    if (v > 64'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
    if (v < -64'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  // Build the move plan from the mirrored registers.
  function automatic void plan_move();
    longint dpos;
    longint unsigned mag, v, a, t1, t2, dur, d, q, r, nd;
    bit clip;
    clip = 0;
    dpos = longint'($signed(m_end)) - longint'($signed(m_start));
    dir_neg = dpos < 0;
    mag = dir_neg ? -dpos : dpos;
    if (mag == 0) mag = 1;
    v = (m_vlim != 0) ? m_vlim : 1;
    a = (m_alim != 0) ? m_alim : 1;
    if (mag * a > v * v) begin
      t1 = (v << F) / a;
      t2 = (mag << F) / v;
      dur = t1 + t2;
      if (dur > T_MAX) begin
        dur = T_MAX;
        clip = 1;
      end
      if (t2 > dur) t2 = dur;
      if (t1 > t2) t1 = t2;
      d = v;
    end else begin
      q = (mag << F) / a;
      r = (mag << F) % a;
      if (q >= (64'd1 << (60 - F))) begin
        t1 = 64'h3FFF_FFFF;
        clip = 1;
      end else begin
        t1 = floor_sqrt((q << F) + ((r << F) / a));
      end
      t2 = t1;
      dur = 2 * t1;
      d = (a * t1) >> F;
      if (d == 0) d = 1;
      if (d > 64'hFFFF_FFFF) begin
        d = 64'hFFFF_FFFF;
        clip = 1;
      end
    end
    p_slope = d;
    // Stretch to the target duration: speed scales by f, acceleration by f*f.
    if (m_tdur != 0 && dur != 0) begin
      nd = m_tdur;
      t1 = t1 * nd / dur;
      t2 = t2 * nd / dur;
      v = v * dur / nd;
      if (v > T_MAX) begin
        v = T_MAX;
        clip = 1;
      end
      a = a * dur / nd;
      if (a > T_MAX) begin
        a = T_MAX;
        clip = 1;
      end else begin
        a = a * dur / nd;
        if (a > T_MAX) begin
          a = T_MAX;
          clip = 1;
        end
      end
      dur = nd;
    end
    p_t1 = t1;
    p_t2 = t2;
    p_total = dur;
    p_vel = v;
    p_acc = a;
    plan_clip = clip;
    plan_valid = 1;
  endfunction

  function automatic profile_t profile_at(logic [31:0] stime);
    profile_t e;
    longint t, pos, sens, vel;
    longint unsigned dmag, vmag, rr, s, a1;
    logic [32:0] c;
    bit sat;
    if (!plan_valid) plan_move();
    sat = plan_clip;
    t = longint'($signed(stime));
    dmag = 0;
    if (t <= 0) begin
      vmag = 0; sens = ONE_Q; pos = longint'($signed(m_start));
    end else if (t < longint'(p_t1)) begin
      vmag = mul_capped(p_acc, t, F);
      dmag = mul_capped(vmag, t, F + 1);
      sens = ONE_Q;
      pos = dir_neg ? longint'($signed(m_start)) - longint'(dmag)
                    : longint'($signed(m_start)) + longint'(dmag);
    end else if (t < longint'(p_t2)) begin
      a1 = mul_capped(p_acc, p_t1, F);
      dmag = mul_capped(a1, p_t1, F + 1) + mul_capped(p_vel, t - longint'(p_t1), F);
      if (dmag > CAP) dmag = CAP;
      vmag = p_vel;
      sens = ONE_Q;
      pos = dir_neg ? longint'($signed(m_start)) - longint'(dmag)
                    : longint'($signed(m_start)) + longint'(dmag);
    end else if (t < longint'(p_total)) begin
      rr = longint'(p_total) - t;
      s = (p_acc * rr) / p_slope;
      vmag = mul_capped(p_acc, rr, F);
      dmag = mul_capped(vmag, rr, F + 1);
      sens = (s > CAP) ? longint'(CAP) : longint'(s);
      pos = dir_neg ? longint'($signed(m_end)) + longint'(dmag)
                    : longint'($signed(m_end)) - longint'(dmag);
    end else begin
      vmag = 0; sens = 0; pos = longint'($signed(m_end));
    end
    vel = dir_neg ? -longint'(vmag) : longint'(vmag);
    c = clamp32(pos);        e.position = c[31:0];   sat |= c[32];
    c = clamp32(vel);        e.velocity = c[31:0];   sat |= c[32];
    c = clamp32(sens);       e.sens_start = c[31:0]; sat |= c[32];
    c = clamp32(ONE_Q - sens); e.sens_end = c[31:0]; sat |= c[32];
    e.move_duration = p_total[30:0];
    e.saturated = sat;
    return e;
  endfunction

  // Pick a sample time aimed at one segment of the current plan, or a random one.
  function automatic logic [31:0] pick_time();
    longint unsigned hi;
    if (!plan_valid) plan_move();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1) != 0) ? 32'd0 : (32'h8000_0000 | $urandom());
      1, 2: return (p_t1 > 1) ? $urandom_range(1, int'(p_t1 - 1)) : 32'd1;
      3, 4: return (p_t2 > p_t1) ? $urandom_range(int'(p_t1), int'(p_t2 - 1)) : p_t1[31:0];
      5, 6: return (p_total > p_t2) ? $urandom_range(int'(p_t2), int'(p_total - 1))
                                    : p_t2[31:0];
      7: begin
        hi = p_total + $urandom_range(0, 1000);
        return (hi > T_MAX) ? 32'h7FFF_FFFF : hi[31:0];
      end
      default: return $urandom();
    endcase
  endfunction

  // Offer one item in bursts with random gaps; record its expected result on accept.
  task automatic send_sample(logic [31:0] stime);
    if (burst_left == 0) begin
      sample.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    sample.valid <= 1'b1;
    sample.sample_time <= stime;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    expected_q.push_back(profile_at(stime));
  endtask

  task automatic drain();
    sample.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write one register over APB; the core must be idle.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      tmp_pkg::REG_START_POS:  m_start = value;
      tmp_pkg::REG_END_POS:    m_end = value;
      tmp_pkg::REG_VEL_LIMIT:  m_vlim = value[30:0];
      tmp_pkg::REG_ACC_LIMIT:  m_alim = value[30:0];
      tmp_pkg::REG_TARGET_DUR: m_tdur = value[30:0];
      default: ;
    endcase
    plan_valid = 0;
  endtask

  task automatic set_plan(logic [31:0] s, logic [31:0] e, logic [31:0] v, logic [31:0] a,
                          logic [31:0] d);
    drain();
    write_reg(tmp_pkg::REG_START_POS, s);
    write_reg(tmp_pkg::REG_END_POS, e);
    write_reg(tmp_pkg::REG_VEL_LIMIT, v);
    write_reg(tmp_pkg::REG_ACC_LIMIT, a);
    write_reg(tmp_pkg::REG_TARGET_DUR, d);
  endtask

  function automatic logic [31:0] rand_limit();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'h7FFF_FFFF;
      3: return $urandom();
      default: return $urandom_range(1 << 12, 1 << 22);
    endcase
  endfunction

  // Reset defaults: unit speed and acceleration, zero-length move.
  task automatic test_reset_plan();
    send_sample(32'd0);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'd1);
    send_sample(32'h0001_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
  endtask

  task automatic test_special_cases();
    // Full-range move at minimum limits: long plan clipped.
    set_plan(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
    send_sample(32'd5);
    send_sample(32'h4000_0000);
    send_sample(32'h7FFF_FFFF);
    // Negative cruise move with a stretched duration.
    set_plan(32'h0100_0000, 32'hFF00_0000, 32'h0002_0000, 32'h0001_0000, 32'h0800_0000);
    for (int i = 0; i < 4; i++) send_sample(pick_time());
    // Tiny move at maximum limits, squeezed to a shorter target: scaled limits overflow.
    set_plan(32'd7, 32'd7, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
    send_sample(32'd0);
    send_sample(32'd1);
    // Triangular move with a clipped ramp time, stretched to the longest target.
    set_plan(32'd0, 32'h7FFF_0000, 32'h7FFF_FFFF, 32'd3, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send_sample(pick_time());
    // Big triangular move with low accel, shrunk to a tiny target: positions near the clip edge.
    set_plan(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0100, 32'h0000_0010);
    for (int i = 0; i < 4; i++) send_sample(pick_time());
  endtask

  task automatic test_random_plans();
    logic [31:0] s, e;
    for (int p = 0; p < 30; p++) begin
      s = $urandom();
      case ($urandom_range(0, 3))
        0: e = s;
        1: e = s + $urandom_range(0, 1 << 18) - (1 << 17);
        2: e = s + $urandom_range(0, 1 << 26) - (1 << 25);
        default: e = $urandom();
      endcase
      set_plan(s, e, rand_limit(), rand_limit(),
               ($urandom_range(0, 1) != 0) ? 32'd0 : $urandom());
      repeat ($urandom_range(10, 25)) send_sample(pick_time());
    end
  endtask

  // Stall the result side for a long stretch while items keep coming.
  task automatic test_backpressure();
    set_plan(32'd0, 32'h0040_0000, 32'h0002_0000, 32'h0004_0000, 32'd0);
    hold_left = 400;
    repeat (20) send_sample(pick_time());
  endtask

  // Result side: stall pattern with calm stretches, plus the long hold-off.
  int rx_mode = 0, rx_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_left <= $urandom_range(1, 40);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        0: result.ready <= 1'b1;
        1: result.ready <= ($urandom_range(0, 1) != 0);
        default: result.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    profile_t exp_r;
    if (!rst && result.valid && result.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
      end else begin
        exp_r = expected_q.pop_front();
        if (result.position !== exp_r.position || result.velocity !== exp_r.velocity ||
            result.sens_start !== exp_r.sens_start || result.sens_end !== exp_r.sens_end ||
            result.move_duration !== exp_r.move_duration ||
            result.saturated !== exp_r.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at %0t: exp pos %h vel %h ss %h se %h dur %h sat %b, ",
                      "got %h %h %h %h %h %b"},
                     $realtime, exp_r.position, exp_r.velocity, exp_r.sens_start,
                     exp_r.sens_end, exp_r.move_duration, exp_r.saturated,
                     result.position, result.velocity, result.sens_start, result.sens_end,
                     result.move_duration, result.saturated);
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    sample.valid <= 1'b0;
    sample.sample_time <= '0;
    m_start = 0;
    m_end = 0;
    m_vlim = 31'd65536;
    m_alim = 31'd65536;
    m_tdur = 0;
    plan_valid = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_plan();
    test_special_cases();
    test_random_plans();
    test_backpressure();
    drain();
    repeat (100) @(posedge clk);
    if (expected_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop in case the core hangs.
  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== trapezoid_motion_profile_core.f =====
hw/rtl/tmp_pkg.sv
hw/rtl/tmp_sample_if.sv
hw/rtl/tmp_result_if.sv
hw/rtl/tmp_front.sv
hw/rtl/tmp_mul.sv
hw/rtl/tmp_div.sv
hw/rtl/tmp_sqrt.sv
hw/rtl/tmp_back.sv
hw/rtl/trapezoid_motion_profile_core.sv
tb/sv/tb_top.sv
